@@ rtl/core/three_wheel_pid_speed_loop_top_defines.svh @@
// Assertion macros for the three-wheel PID speed loop.
// Included by the top level; no other dependencies.
`ifndef THREE_WHEEL_PID_SPEED_LOOP_TOP_DEFINES_SVH
`define THREE_WHEEL_PID_SPEED_LOOP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TPSL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tpsl assertion failed");
`define TPSL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tpsl assertion failed");
`else
`define TPSL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TPSL_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/core/tpsl_pkg.sv @@
// Shared types and constants for the three-wheel PID speed loop.
// No dependencies; used by every module of the block.
`default_nettype none

package tpsl_pkg;

  localparam int LANES = 3;

  typedef enum logic [2:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_INTEGRAL_UPPER = 3'd3,
    CFG_INTEGRAL_LOWER = 3'd4,
    CFG_ERROR_LIMIT    = 3'd5
  } cfg_idx_e;

  localparam logic [15:0]        GAIN_P_RST         = 16'd410;
  localparam logic [15:0]        GAIN_I_RST         = 16'd205;
  localparam logic [15:0]        GAIN_D_RST         = 16'd410;
  localparam logic signed [15:0] INTEGRAL_UPPER_RST = 16'sd3200;
  localparam logic signed [15:0] INTEGRAL_LOWER_RST = -16'sd3200;
  localparam logic [14:0]        ERROR_LIMIT_RST    = 15'd800;

  localparam logic signed [24:0] INTEG_MAX = 25'sd8388607;
  localparam logic signed [24:0] INTEG_MIN = -25'sd8388608;
  localparam logic signed [29:0] DRIVE_MAX = 30'sd32767;
  localparam logic signed [29:0] DRIVE_MIN = -30'sd32768;
  localparam logic signed [41:0] ROUND_HALF = 42'sd2048;

  typedef struct packed {
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic signed [15:0] integral_upper;
    logic signed [15:0] integral_lower;
    logic [14:0]        error_limit;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic adv2;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/tpsl_lane.sv @@
// One wheel lane: error, integrator update, three gain products, rounding and saturation.
// Depends on tpsl_pkg.
`default_nettype none

module tpsl_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpsl_pkg::cfg_t     cfg_i,
  input  tpsl_pkg::lane_ctrl_t ctrl_i,
  input  logic signed [15:0] target_i,
  input  logic signed [15:0] measured_i,
  output logic signed [15:0] drive_o
);
  import tpsl_pkg::*;

  logic signed [23:0] integ_q, integ_d;
  logic signed [16:0] prev_q;

  logic signed [16:0] err;
  logic signed [17:0] diff;
  logic [16:0]        mag;
  logic               upd;
  logic signed [24:0] isum;
  logic signed [15:0] upper, lower;

  logic signed [16:0] err1_q;
  logic signed [17:0] diff1_q;
  logic signed [23:0] integ1_q;
  logic               use_i1_q;
  logic signed [15:0] tgt1_q;

  logic signed [33:0] prod_p2_q;
  logic signed [34:0] prod_d2_q;
  logic signed [40:0] prod_i2_q;
  logic signed [15:0] tgt2_q;

  logic signed [41:0] acc;
  logic signed [41:0] acc_r;
  logic signed [28:0] corr;
  logic signed [29:0] drv;

  assign upper = $signed(cfg_i.integral_upper);
  assign lower = $signed(cfg_i.integral_lower);

  assign err  = 17'(target_i) - 17'(measured_i);
  assign diff = 18'(err) - 18'(prev_q);
  assign mag  = err[16] ? 17'(-err) : 17'(err);

  always_comb begin
    upd = ((integ_q < upper) && (integ_q > lower)) ||
          ((integ_q > upper) && err[16]) ||
          ((integ_q < lower) && !err[16] && (err != 17'sd0));
    isum = 25'(integ_q) + 25'(err);
    integ_d = integ_q;
    if (upd) begin
      if (isum > INTEG_MAX) begin
        integ_d = INTEG_MAX[23:0];
      end else if (isum < INTEG_MIN) begin
        integ_d = INTEG_MIN[23:0];
      end else begin
        integ_d = isum[23:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (ctrl_i.accept) begin
      integ_q <= integ_d;
      prev_q  <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      err1_q   <= err;
      diff1_q  <= diff;
      integ1_q <= integ_d;
      use_i1_q <= (mag <= 17'(cfg_i.error_limit));
      tgt1_q   <= target_i;
    end
    if (ctrl_i.adv2) begin
      prod_p2_q <= $signed({1'b0, cfg_i.gain_p}) * err1_q;
      prod_d2_q <= $signed({1'b0, cfg_i.gain_d}) * diff1_q;
      prod_i2_q <= use_i1_q ? $signed({1'b0, cfg_i.gain_i}) * integ1_q : 41'sd0;
      tgt2_q    <= tgt1_q;
    end
  end

  always_comb begin
    acc   = 42'(prod_p2_q) + 42'(prod_d2_q) + 42'(prod_i2_q);
    acc_r = (acc + ROUND_HALF) >>> 12;
    corr  = acc_r[28:0];
    drv   = 30'(tgt2_q) + 30'(corr);
    if (drv > DRIVE_MAX) begin
      drive_o = DRIVE_MAX[15:0];
    end else if (drv < DRIVE_MIN) begin
      drive_o = DRIVE_MIN[15:0];
    end else begin
      drive_o = drv[15:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tpsl_merge.sv @@
// Output stage: joins the lane drive values into one result word and holds it for the sink.
// Depends on tpsl_pkg.
`default_nettype none

module tpsl_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] lane_drive_i [tpsl_pkg::LANES],
  output logic               out_valid_o,
  output logic signed [15:0] drive_o [tpsl_pkg::LANES]
);
  import tpsl_pkg::*;

  logic valid_q, valid_d;
  logic signed [15:0] drive_q [LANES];

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q <= lane_drive_i;
    end
  end

  assign out_valid_o = valid_q;
  assign drive_o     = drive_q;

endmodule

`default_nettype wire

@@ rtl/core/three_wheel_pid_speed_loop_top.sv @@
// Top level of the three-wheel PID speed loop: configuration registers, pipeline control,
// three wheel lanes and the output stage. Depends on tpsl_pkg, tpsl_lane, tpsl_merge.
//
// One word carries target and measured speed for three wheels; one drive word comes back
// per input word. Accepts one word per cycle while the output is not stalled. Error and
// integrator are registered at acceptance, then the gain products are registered, then
// rounding and saturation go into the output register, which presents the drive word. The
// per-wheel integrator and previous error update in the accept cycle, so consecutive words
// need no spacing. Write configuration only while no word is in flight; cfg_ready_o is
// always high and unknown indexes are ignored.
`default_nettype none

`include "three_wheel_pid_speed_loop_top_defines.svh"

module three_wheel_pid_speed_loop_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] target_a_i,
  input  logic signed [15:0] measured_a_i,
  input  logic signed [15:0] target_b_i,
  input  logic signed [15:0] measured_b_i,
  input  logic signed [15:0] target_c_i,
  input  logic signed [15:0] measured_c_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] drive_a_o,
  output logic signed [15:0] drive_b_o,
  output logic signed [15:0] drive_c_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import tpsl_pkg::*;

  cfg_t       cfg_q, cfg_d;
  lane_ctrl_t ctrl;
  logic       v1_q, v1_d, v2_q, v2_d;
  logic       ld_out;

  logic signed [15:0] target   [LANES];
  logic signed [15:0] measured [LANES];
  logic signed [15:0] lane_drive [LANES];
  logic signed [15:0] drive      [LANES];

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_P:         cfg_d.gain_p         = cfg_data_i;
        CFG_GAIN_I:         cfg_d.gain_i         = cfg_data_i;
        CFG_GAIN_D:         cfg_d.gain_d         = cfg_data_i;
        CFG_INTEGRAL_UPPER: cfg_d.integral_upper = $signed(cfg_data_i);
        CFG_INTEGRAL_LOWER: cfg_d.integral_lower = $signed(cfg_data_i);
        CFG_ERROR_LIMIT:    cfg_d.error_limit    = cfg_data_i[14:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= GAIN_P_RST;
      cfg_q.gain_i         <= GAIN_I_RST;
      cfg_q.gain_d         <= GAIN_D_RST;
      cfg_q.integral_upper <= INTEGRAL_UPPER_RST;
      cfg_q.integral_lower <= INTEGRAL_LOWER_RST;
      cfg_q.error_limit    <= ERROR_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign ld_out      = v2_q && (!out_valid_o || out_ready_i);
  assign ctrl.adv2   = v1_q && (!v2_q || ld_out);
  assign in_ready_o  = !v1_q || ctrl.adv2;
  assign ctrl.accept = in_valid_i && in_ready_o;

  always_comb begin
    v1_d = v1_q;
    if (ctrl.accept) begin
      v1_d = 1'b1;
    end else if (ctrl.adv2) begin
      v1_d = 1'b0;
    end
    v2_d = v2_q;
    if (ctrl.adv2) begin
      v2_d = 1'b1;
    end else if (ld_out) begin
      v2_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  assign target[0]   = target_a_i;
  assign measured[0] = measured_a_i;
  assign target[1]   = target_b_i;
  assign measured[1] = measured_b_i;
  assign target[2]   = target_c_i;
  assign measured[2] = measured_c_i;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tpsl_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_i      (cfg_q),
      .ctrl_i     (ctrl),
      .target_i   (target[g]),
      .measured_i (measured[g]),
      .drive_o    (lane_drive[g])
    );
  end

  tpsl_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (ld_out),
    .out_ready_i  (out_ready_i),
    .lane_drive_i (lane_drive),
    .out_valid_o  (out_valid_o),
    .drive_o      (drive)
  );

  assign drive_a_o = drive[0];
  assign drive_b_o = drive[1];
  assign drive_c_o = drive[2];

  `TPSL_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o, v1_q && v2_q && out_valid_o)
  `TPSL_ASSERT_NXT(a_drain_to_output, clk_i, rst_ni, v2_q && !out_valid_o, out_valid_o)
  `TPSL_ASSERT_NXT(a_output_empties, clk_i, rst_ni, out_valid_o && out_ready_i && !v2_q, !out_valid_o)

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for three_wheel_pid_speed_loop_top: directed and random speed words,
// each drive word checked against an in-bench PID predictor. Depends on tpsl_pkg and the RTL.

module tb_top;
  import tpsl_pkg::*;

  localparam int          DRIVE_LATENCY  = 3;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam logic [2:0]  CFG_SPARE_A    = 3'd6;
  localparam logic [2:0]  CFG_SPARE_B    = 3'd7;
  localparam int          INTEG_HI       = 8388607;
  localparam int          INTEG_LO       = -8388608;

  typedef logic [LANES-1:0][15:0] lane_word_t;

  typedef enum int {
    STYLE_NOISE,
    STYLE_NEAR,
    STYLE_PUSH_UP,
    STYLE_PUSH_DOWN
  } err_style_e;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [15:0] target_a_i   = '0;
  logic [15:0] measured_a_i = '0;
  logic [15:0] target_b_i   = '0;
  logic [15:0] measured_b_i = '0;
  logic [15:0] target_c_i   = '0;
  logic [15:0] measured_c_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [15:0] drive_a_o;
  logic [15:0] drive_b_o;
  logic [15:0] drive_c_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i  = '0;
  logic [15:0] cfg_data_i   = '0;

  cfg_t       model_cfg;
  int         integ_st[LANES];
  int         prev_err_st[LANES];
  lane_word_t pending_drives[$];
  lane_word_t want_drive;
  lane_word_t got_drive;
  int         mismatches     = 0;
  int         stall_cycles   = 0;
  int         send_idle_pct  = 0;
  int         sink_idle_pct  = 0;

  three_wheel_pid_speed_loop_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .target_a_i  (target_a_i),
    .measured_a_i(measured_a_i),
    .target_b_i  (target_b_i),
    .measured_b_i(measured_b_i),
    .target_c_i  (target_c_i),
    .measured_c_i(measured_c_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_a_o   (drive_a_o),
    .drive_b_o   (drive_b_o),
    .drive_c_o   (drive_c_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic lane_word_t pid_drive_next(input lane_word_t tgt, input lane_word_t meas);
    lane_word_t drv;
    int         t, m, e, i, mag, hi, lo, lim;
    longint     acc, s, d;
    bit         upd;
    hi  = $signed(model_cfg.integral_upper);
    lo  = $signed(model_cfg.integral_lower);
    lim = int'(model_cfg.error_limit);
    for (int w = 0; w < LANES; w++) begin
      t   = $signed(tgt[w]);
      m   = $signed(meas[w]);
      e   = t - m;
      i   = integ_st[w];
      mag = (e < 0) ? -e : e;
      upd = (i < hi && i > lo) || (i > hi && e < 0) || (i < lo && e > 0);
      if (upd) begin
        s = longint'(i) + e;
        if (s > INTEG_HI) s = INTEG_HI;
        if (s < INTEG_LO) s = INTEG_LO;
        i = int'(s);
        integ_st[w] = i;
      end
      acc = longint'(model_cfg.gain_p) * e;
      acc += longint'(model_cfg.gain_d) * (longint'(e) - prev_err_st[w]);
      if (mag <= lim) acc += longint'(model_cfg.gain_i) * i;
      d = longint'(t) + ((acc + 2048) >>> 12);
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      drv[w] = d[15:0];
      prev_err_st[w] = e;
    end
    return drv;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_drives.size() == 0) begin
        note_mismatch($sformatf("drive word %h %h %h with none expected",
                                drive_a_o, drive_b_o, drive_c_o));
      end else begin
        want_drive = pending_drives.pop_front();
        got_drive  = {drive_c_o, drive_b_o, drive_a_o};
        for (int w = 0; w < LANES; w++) begin
          if (got_drive[w] !== want_drive[w]) begin
            note_mismatch($sformatf("wheel %0d drive expected %0d got %0d", w,
                                    $signed(want_drive[w]), $signed(got_drive[w])));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_speeds(input lane_word_t tgt, input lane_word_t meas);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    target_a_i   <= tgt[0];
    target_b_i   <= tgt[1];
    target_c_i   <= tgt[2];
    measured_a_i <= meas[0];
    measured_b_i <= meas[1];
    measured_c_i <= meas[2];
    do @(posedge clk_i); while (!in_ready_o);
    pending_drives.push_back(pid_drive_next(tgt, meas));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_GAIN_P:         model_cfg.gain_p         = data;
      CFG_GAIN_I:         model_cfg.gain_i         = data;
      CFG_GAIN_D:         model_cfg.gain_d         = data;
      CFG_INTEGRAL_UPPER: model_cfg.integral_upper = data;
      CFG_INTEGRAL_LOWER: model_cfg.integral_lower = data;
      CFG_ERROR_LIMIT:    model_cfg.error_limit    = data[14:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input cfg_t c);
    wait_drained();
    write_reg(CFG_GAIN_P, c.gain_p);
    write_reg(CFG_GAIN_I, c.gain_i);
    write_reg(CFG_GAIN_D, c.gain_d);
    write_reg(CFG_INTEGRAL_UPPER, c.integral_upper);
    write_reg(CFG_INTEGRAL_LOWER, c.integral_lower);
    write_reg(CFG_ERROR_LIMIT, {1'($urandom), c.error_limit});
    write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(8191));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.gain_p = rand_gain();
    c.gain_i = rand_gain();
    c.gain_d = rand_gain();
    if ($urandom_range(9) == 0) begin
      c.integral_upper = 16'($urandom);
      c.integral_lower = 16'($urandom);
    end else begin
      c.integral_upper = 16'($urandom_range(4000));
      c.integral_lower = 16'(-int'($urandom_range(4000)));
    end
    case ($urandom_range(9))
      0:       c.error_limit = 15'h0000;
      1:       c.error_limit = 15'h7FFF;
      2:       c.error_limit = 15'($urandom);
      default: c.error_limit = 15'($urandom_range(1600));
    endcase
    return c;
  endfunction

  function automatic void rand_speeds(input err_style_e style, output lane_word_t tgt,
                                      output lane_word_t meas);
    int t, e;
    for (int w = 0; w < LANES; w++) begin
      if (style == STYLE_NOISE) begin
        tgt[w]  = 16'($urandom);
        meas[w] = 16'($urandom);
      end else begin
        t = int'($urandom_range(8000)) - 4000;
        case (style)
          STYLE_NEAR:    e = int'($urandom_range(128)) - 64;
          STYLE_PUSH_UP: e = int'($urandom_range(600));
          default:       e = -int'($urandom_range(600));
        endcase
        tgt[w]  = 16'(t);
        meas[w] = 16'(t - e);
      end
    end
  endfunction

  // reset gains and bounds stay in force here
  task automatic test_reset_values();
    send_speeds({3{16'h0000}}, {3{16'h0000}});
    send_speeds({16'h0321, 16'hFCE0, 16'h0320}, {3{16'h0000}});
  endtask

  task automatic test_integral_bounds();
    load_cfg({16'd0, 16'd4096, 16'd0, 16'h03E8, 16'hFC18, 15'h7FFF});
    send_speeds({3{16'h012C}}, {3{16'h0000}});
    send_speeds({3{16'h012C}}, {3{16'h0000}});
    send_speeds({3{16'hFF9C}}, {3{16'h0000}});
    send_speeds({3{16'hFFFF}}, {3{16'h0000}});
    send_speeds({3{16'h0001}}, {3{16'h0000}});
    // swap the bounds so only pull-back can move the integrator
    load_cfg({16'd0, 16'd4096, 16'd0, 16'hFC18, 16'h03E8, 15'h7FFF});
    send_speeds({3{16'hFFFB}}, {3{16'h0000}});
    send_speeds({3{16'h0005}}, {3{16'h0000}});
    send_speeds({3{16'h0005}}, {3{16'h0000}});
  endtask

  task automatic test_error_separation();
    load_cfg({16'd0, 16'd4096, 16'd0, 16'h7FFF, 16'h8000, 15'h0000});
    send_speeds({16'hFFFF, 16'h0001, 16'h0000}, {3{16'h0000}});
    load_cfg({16'd0, 16'd4096, 16'd0, 16'h7FFF, 16'h8000, 15'h7FFF});
    send_speeds({16'h0000, 16'h8001, 16'h7FFF}, {16'h8000, 16'h0000, 16'h0000});
    send_speeds({16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h0000});
  endtask

  task automatic test_rounding_ties();
    load_cfg({16'd2048, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 15'h7FFF});
    send_speeds({16'h0003, 16'hFFFF, 16'h0001}, {3{16'h0000}});
    send_speeds({16'hFFFD, 16'h0002, 16'hFFFE}, {3{16'h0000}});
  endtask

  task automatic test_field_extremes();
    load_cfg({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 15'h7FFF});
    send_speeds({3{16'h7FFF}}, {3{16'h8000}});
    send_speeds({3{16'h8000}}, {3{16'h7FFF}});
    send_speeds({3{16'h7FFF}}, {3{16'h7FFF}});
    send_speeds({3{16'h8000}}, {3{16'h8000}});
    send_speeds({16'h0000, 16'h8000, 16'h7FFF}, {16'h7FFF, 16'h0000, 16'h8000});
    load_cfg({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0000});
    send_speeds({3{16'h7FFF}}, {3{16'h8000}});
    send_speeds({3{16'h8000}}, {3{16'h0000}});
  endtask

  task automatic test_random_traffic();
    lane_word_t tgt, meas;
    err_style_e style;
    int         pick;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 22; sink_idle_pct = 78; end
        1:       begin send_idle_pct = 78; sink_idle_pct = 22; end
        default: begin send_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      for (int chunk = 0; chunk < 4; chunk++) begin
        load_cfg(rand_cfg());
        for (int run = 0; run < 5; run++) begin
          pick = $urandom_range(99);
          if (pick < 20)      style = STYLE_NOISE;
          else if (pick < 50) style = STYLE_NEAR;
          else if (pick < 75) style = STYLE_PUSH_UP;
          else                style = STYLE_PUSH_DOWN;
          repeat (20) begin
            rand_speeds(style, tgt, meas);
            send_speeds(tgt, meas);
          end
        end
      end
    end
  endtask

  initial begin
    model_cfg = {16'd410, 16'd205, 16'd410, 16'sd3200, -16'sd3200, 15'd800};
    for (int w = 0; w < LANES; w++) begin
      integ_st[w]    = 0;
      prev_err_st[w] = 0;
    end
    send_idle_pct = 22;
    sink_idle_pct = 78;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_integral_bounds();
    test_error_separation();
    test_rounding_ties();
    test_field_extremes();
    test_random_traffic();
    wait_drained();
    repeat (DRIVE_LATENCY + 2) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
